// ===== design/hcps_pkg.sv =====
// ----------------------------------------------------------------------------
// hcps_pkg
// Shared types and constants of the heating channel poll sequencer.
// ----------------------------------------------------------------------------
package hcps_pkg;

  // Default number of polled channels and the reset reply timeout.
  localparam int unsigned NumChannelsDef = 16;
  localparam logic [15:0] TimeoutReset   = 16'd1000;

  // Input item selector codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_REQ     = 3'd0;
  localparam logic [2:0] KIND_STATUS  = 3'd1;
  localparam logic [2:0] KIND_TEMP    = 3'd2;
  localparam logic [2:0] KIND_TARGET  = 3'd3;
  localparam logic [2:0] KIND_MODE    = 3'd4;
  localparam logic [2:0] KIND_OVERRUN = 3'd5;

  // Per-channel poll phases.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_STATUS  = 3'd1;
  localparam logic [2:0] PH_ELEMENT = 3'd2;
  localparam logic [2:0] PH_TARGET  = 3'd3;
  localparam logic [2:0] PH_MODE    = 3'd4;

  // Register addresses (category in the high byte) and register counts.
  localparam logic [15:0] ADDR_STATUS  = 16'h0300;
  localparam logic [15:0] ADDR_ELEMENT = 16'h0104;
  localparam logic [15:0] ADDR_TARGET  = 16'h0200;
  localparam logic [15:0] ADDR_MODE    = 16'h0207;
  localparam logic [7:0]  CNT_STATUS   = 8'd3;
  localparam logic [7:0]  CNT_ELEMENT  = 8'd7;
  localparam logic [7:0]  CNT_TARGET   = 8'd1;
  localparam logic [7:0]  CNT_MODE     = 8'd1;

  // Reply decoding masks.
  localparam logic [7:0] ELEM_MASK     = 8'h3f;
  localparam logic [7:0] FLAG_LOST     = 8'h02;
  localparam logic [7:0] FLAG_OUTPUT   = 8'h10;
  localparam logic [7:0] MODE_BITS     = 8'h07;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte5;
    logic [7:0] byte13;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [3:0]  channel_number;
    logic [15:0] request_address;
    logic [15:0] request_word;
    logic        heat_on;
    logic [15:0] temperature_tenths;
    logic [11:0] battery_level;
    logic [2:0]  mode_value;
  } result_t;

endpackage

// ===== design/heating_channel_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// heating_channel_poll_sequencer
// Polls floor-heating channels over a register bus, one phase per tick.
// ----------------------------------------------------------------------------
// A result word reaches the master side through the input register, loaded
// when its input word is accepted, and then the result register.
// Throughput: one input word per cycle, set by the state update in hcps_core;
// the input stalls only while the result register is full and its word is
// not being taken.
// Reset is asynchronous and active low; it clears the sweep state and sets the
// reply timeout to 1000 ticks.
// ----------------------------------------------------------------------------
module heating_channel_poll_sequencer import hcps_pkg::*; #(
  parameter int unsigned NumChannels = NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: reply timeout in ticks.
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Input words.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata from bit 0 up: reply_byte0, reply_byte1, reply_byte5, reply_byte13.
  input  logic [31:0] s_axis_tdata_i,
  // tuser: op.
  input  logic [1:0]  s_axis_tuser_i,
  // Result words.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata from bit 0 up: channel_number, request_address, request_word,
  // heat_on, temperature_tenths, battery_level, mode_value, 4 zero bits.
  output logic [71:0] m_axis_tdata_o,
  // tuser: kind.
  output logic [2:0]  m_axis_tuser_o
);

  logic [15:0] timeout_q;
  logic        in_valid_q;
  item_t       in_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        out_free;
  logic        proc_fire;
  result_t     res;

  // The user must write the timeout register only while the sequencer is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // The registered item is processed whenever the result register can take
  // whatever it produces; the input register refills in the same cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc_fire       = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.op     <= s_axis_tuser_i;
      in_q.byte0  <= s_axis_tdata_i[7:0];
      in_q.byte1  <= s_axis_tdata_i[15:8];
      in_q.byte5  <= s_axis_tdata_i[23:16];
      in_q.byte13 <= s_axis_tdata_i[31:24];
    end
  end

  hcps_core #(
    .NumChannels(NumChannels)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (proc_fire),
    .item_i   (in_q),
    .timeout_i(timeout_q),
    .res_o    (res)
  );

  // Items that produce no result still pass through, leaving the result
  // register empty once its previous word has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {4'd0,
                            out_q.mode_value,
                            out_q.battery_level,
                            out_q.temperature_tenths,
                            out_q.heat_on,
                            out_q.request_word,
                            out_q.request_address,
                            out_q.channel_number};

endmodule

// ===== design/hcps_core.sv =====
// ----------------------------------------------------------------------------
// hcps_core
// Sequencer state and the combinational decode of one item into at most one
// result.
// ----------------------------------------------------------------------------
module hcps_core import hcps_pkg::*; #(
  parameter int unsigned NumChannels = NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  item_t       item_i,
  input  logic [15:0] timeout_i,
  output result_t     res_o
);

  logic        sweep_q, sweep_d;
  logic [3:0]  ch_q, ch_d;
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  elem_q, elem_d;
  logic        await_q, await_d;
  logic [15:0] ticks_q, ticks_d;

  logic [2:0]  ph_cur;
  logic [2:0]  ph_nxt;
  logic        advance;
  logic        last_ch;
  logic [5:0]  elem_rx;

  assign last_ch = (5'({1'b0, ch_q}) + 5'd1) >= 5'(NumChannels);
  assign elem_rx = item_i.byte5[5:0] & ELEM_MASK[5:0];

  always_comb begin
    sweep_d = sweep_q;
    ch_d    = ch_q;
    phase_d = phase_q;
    elem_d  = elem_q;
    await_d = await_q;
    ticks_d = ticks_q;
    res_o   = '0;
    ph_cur  = phase_q;
    ph_nxt  = phase_q;
    advance = 1'b0;
    if (fire_i) begin
      unique case (item_i.op)
        OP_TICK: begin
          if (sweep_q) begin
            advance = 1'b1;
            if (await_q) begin
              if (ticks_q >= timeout_i) begin
                // Reply lost: end this channel and move on in the same tick.
                ph_cur  = PH_MODE;
                await_d = 1'b0;
              end else begin
                ticks_d = 16'(ticks_q + 16'd1);
                advance = 1'b0;
              end
            end
            if (advance) begin
              ph_nxt = 3'(ph_cur + 3'd1);
              if (ph_nxt > PH_MODE) begin
                if (last_ch) begin
                  sweep_d = 1'b0;
                  phase_d = PH_IDLE;
                  ch_d    = '0;
                  advance = 1'b0;
                end else begin
                  ch_d   = 4'(ch_q + 4'd1);
                  ph_nxt = PH_STATUS;
                end
              end
            end
            if (advance) begin
              phase_d              = ph_nxt;
              await_d              = 1'b1;
              ticks_d              = '0;
              res_o.valid          = 1'b1;
              res_o.kind           = KIND_REQ;
              res_o.channel_number = ch_d;
              unique case (ph_nxt)
                PH_STATUS: begin
                  res_o.request_address = ADDR_STATUS;
                  res_o.request_word    = {4'd0, ch_d, CNT_STATUS};
                end
                PH_ELEMENT: begin
                  res_o.request_address = ADDR_ELEMENT;
                  res_o.request_word    = {2'd0, elem_q, CNT_ELEMENT};
                end
                PH_TARGET: begin
                  res_o.request_address = ADDR_TARGET;
                  res_o.request_word    = {4'd0, ch_d, CNT_TARGET};
                end
                default: begin
                  res_o.request_address = ADDR_MODE;
                  res_o.request_word    = {4'd0, ch_d, CNT_MODE};
                end
              endcase
            end
          end
        end
        OP_START: begin
          if (await_q) begin
            res_o.valid          = 1'b1;
            res_o.kind           = KIND_OVERRUN;
            res_o.channel_number = ch_q;
          end else begin
            sweep_d = 1'b1;
            ch_d    = '0;
            phase_d = PH_IDLE;
          end
        end
        OP_REPLY: begin
          await_d              = 1'b0;
          res_o.channel_number = ch_q;
          unique case (phase_q)
            PH_STATUS: begin
              elem_d = elem_rx;
              if (elem_rx == 6'd0) begin
                // Unused channel: skip straight to its end.
                phase_d = PH_MODE;
              end else begin
                if ((item_i.byte0 & FLAG_LOST) != 8'd0) begin
                  phase_d = PH_ELEMENT;
                end
                res_o.valid   = 1'b1;
                res_o.kind    = KIND_STATUS;
                res_o.heat_on = (item_i.byte0 & FLAG_OUTPUT) != 8'd0;
              end
            end
            PH_ELEMENT: begin
              res_o.valid              = 1'b1;
              res_o.kind               = KIND_TEMP;
              res_o.temperature_tenths = {item_i.byte0, item_i.byte1};
              res_o.battery_level      = 12'({item_i.byte13, 3'b000})
                                       + 12'({item_i.byte13, 1'b0});
            end
            PH_TARGET: begin
              res_o.valid              = 1'b1;
              res_o.kind               = KIND_TARGET;
              res_o.temperature_tenths = {item_i.byte0, item_i.byte1};
            end
            PH_MODE: begin
              res_o.valid      = 1'b1;
              res_o.kind       = KIND_MODE;
              res_o.mode_value = item_i.byte0[2:0] & MODE_BITS[2:0];
            end
            default: begin
              res_o.valid = 1'b0;
            end
          endcase
        end
        default: begin
          res_o.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= 1'b0;
      ch_q    <= '0;
      phase_q <= PH_IDLE;
      elem_q  <= '0;
      await_q <= 1'b0;
      ticks_q <= '0;
    end else begin
      sweep_q <= sweep_d;
      ch_q    <= ch_d;
      phase_q <= phase_d;
      elem_q  <= elem_d;
      await_q <= await_d;
      ticks_q <= ticks_d;
    end
  end

  // A reply can only be outstanding during a sweep.
  a_await_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    await_q |-> sweep_q)
    else $error("reply outstanding outside a sweep");

  // Every request arms the reply wait with a fresh tick count.
  a_req_arms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_REQ) |=> (await_q && ticks_q == 16'd0))
    else $error("request did not arm the reply wait");

  // Overrun is only reported while a reply is outstanding.
  a_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_OVERRUN) |-> await_q)
    else $error("overrun without an outstanding reply");

  // The channel counter stays inside the configured channel range.
  a_ch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    5'({1'b0, ch_q}) < 5'(NumChannels))
    else $error("channel counter out of range");

endmodule

// ===== tb/hcps_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcps_tb_pkg
// Scoreboard for the heating channel poll sequencer: a cycle-free copy of the
// poll state that predicts each result word, and an in-order result check.
// ----------------------------------------------------------------------------
package hcps_tb_pkg;

  import hcps_pkg::*;

  // The fourth selector code carries no meaning and must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class channel_poll_scoreboard;
    logic        sweeping;
    logic [3:0]  chan;
    logic [2:0]  poll_phase;
    logic [5:0]  elem_num;
    logic        reply_due;
    logic [15:0] ticks_waited;
    logic [15:0] timeout_ticks;
    result_t     due_results[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      sweeping      = 1'b0;
      chan          = '0;
      poll_phase    = PH_IDLE;
      elem_num      = '0;
      reply_due     = 1'b0;
      ticks_waited  = '0;
      timeout_ticks = TimeoutReset;
      mismatches    = 0;
      results_seen  = 0;
    endfunction

    function result_t blank_result(logic [2:0] kind);
      result_t r;
      r                = '0;
      r.valid          = 1'b1;
      r.kind           = kind;
      r.channel_number = chan;
      return r;
    endfunction

    // Updates the poll state for one accepted input word and queues the
    // result word it causes, if any.
    function void take_input(logic [1:0] op, logic [31:0] data);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b5;
      logic [7:0] b13;
      result_t    r;
      b0  = data[7:0];
      b1  = data[15:8];
      b5  = data[23:16];
      b13 = data[31:24];
      case (op)
        OP_TICK: begin
          if (!sweeping) return;
          if (reply_due) begin
            if (ticks_waited < timeout_ticks) begin
              ticks_waited++;
              return;
            end
            // The reply is lost: give up on the channel and move on.
            poll_phase = PH_MODE;
            reply_due  = 1'b0;
          end
          if (poll_phase >= PH_MODE) begin
            if (int'(chan) + 1 >= NumChannelsDef) begin
              sweeping   = 1'b0;
              poll_phase = PH_IDLE;
              chan       = '0;
              return;
            end
            chan++;
            poll_phase = PH_STATUS;
          end else begin
            poll_phase++;
          end
          r = blank_result(KIND_REQ);
          case (poll_phase)
            PH_STATUS: begin
              r.request_address = ADDR_STATUS;
              r.request_word    = {4'b0, chan, CNT_STATUS};
            end
            PH_ELEMENT: begin
              r.request_address = ADDR_ELEMENT;
              r.request_word    = {2'b0, elem_num, CNT_ELEMENT};
            end
            PH_TARGET: begin
              r.request_address = ADDR_TARGET;
              r.request_word    = {4'b0, chan, CNT_TARGET};
            end
            default: begin
              r.request_address = ADDR_MODE;
              r.request_word    = {4'b0, chan, CNT_MODE};
            end
          endcase
          reply_due    = 1'b1;
          ticks_waited = '0;
          due_results.push_back(r);
        end
        OP_START: begin
          if (reply_due) begin
            due_results.push_back(blank_result(KIND_OVERRUN));
          end else begin
            sweeping   = 1'b1;
            chan       = '0;
            poll_phase = PH_IDLE;
          end
        end
        OP_REPLY: begin
          // A reply is decoded by the current phase even when none was asked.
          reply_due = 1'b0;
          case (poll_phase)
            PH_STATUS: begin
              elem_num = 6'(b5 & ELEM_MASK);
              if (elem_num == '0) begin
                poll_phase = PH_MODE;
              end else begin
                if ((b0 & FLAG_LOST) != '0) poll_phase = PH_ELEMENT;
                r         = blank_result(KIND_STATUS);
                r.heat_on = (b0 & FLAG_OUTPUT) != '0;
                due_results.push_back(r);
              end
            end
            PH_ELEMENT: begin
              r                    = blank_result(KIND_TEMP);
              r.temperature_tenths = {b0, b1};
              r.battery_level      = 12'(int'(b13) * 10);
              due_results.push_back(r);
            end
            PH_TARGET: begin
              r                    = blank_result(KIND_TARGET);
              r.temperature_tenths = {b0, b1};
              due_results.push_back(r);
            end
            PH_MODE: begin
              r            = blank_result(KIND_MODE);
              r.mode_value = 3'(b0 & MODE_BITS);
              due_results.push_back(r);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s: got 'h%0h, expected 'h%0h",
                                  results_seen, name, got, want));
      end
    endtask

    // Checks one accepted result word against the oldest expectation.
    task check_output(logic [2:0] kind, logic [71:0] data);
      result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result %0d of kind %0d arrived with nothing expected",
                                  results_seen, kind));
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", 16'(kind), 16'(want.kind));
      compare_field("channel_number", 16'(data[3:0]), 16'(want.channel_number));
      compare_field("request_address", data[19:4], want.request_address);
      compare_field("request_word", data[35:20], want.request_word);
      compare_field("heat_on", 16'(data[36]), 16'(want.heat_on));
      compare_field("temperature_tenths", data[52:37], want.temperature_tenths);
      compare_field("battery_level", 16'(data[64:53]), 16'(want.battery_level));
      compare_field("mode_value", 16'(data[67:65]), 16'(want.mode_value));
      compare_field("padding", 16'(data[71:68]), 16'h0);
    endtask
  endclass

endpackage

// ===== tb/heating_channel_poll_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// heating_channel_poll_sequencer_test
// Drives tick, start and reply words into the poll sequencer, predicts every
// request, decoded reply and overrun word, and checks them in order, under
// random idling on both streams and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module heating_channel_poll_sequencer_test;

  timeunit 1ns;
  timeprecision 1ps;

  import hcps_pkg::*;
  import hcps_tb_pkg::*;

  // Cycles to let pass once nothing is expected any more; a taken word goes
  // through the input and then the result register, so this leaves a good margin.
  localparam int unsigned DrainCycles = 8;
  // Result side hold-off, long enough to fill the block and stall its input.
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 150;
  // The longest correct stretch without any accepted word is the hold-off
  // plus a drain; the limit is that several times over.
  localparam int unsigned StallLimit  = 4000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic        s_ready;
  logic [31:0] s_data    = '0;
  logic [1:0]  s_user    = OP_TICK;
  logic        m_valid;
  logic        m_ready   = 1'b0;
  logic [71:0] m_data;
  logic [2:0]  m_user;

  // While set, neither side idles.
  bit          steady    = 1'b0;
  bit          hold_done = 1'b0;

  channel_poll_scoreboard sb = new();

  heating_channel_poll_sequencer u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reply bytes packed the way the input tdata carries them, byte0 lowest.
  function automatic logic [31:0] reply_word(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b5, logic [7:0] b13);
    return {b13, b5, b1, b0};
  endfunction

  // Offers one word and returns at the edge where it is taken. An idle gap
  // is inserted now and then; valid is only lowered in a step where it is
  // not raised again, so a word that follows at once keeps valid high.
  task automatic send_word(logic [1:0] op, logic [31:0] data);
    if (!steady && $urandom_range(0, 99) < 4) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= data;
    do @(posedge clk_i); while (!s_ready);
    sb.take_input(op, data);
  endtask

  // The timeout register is only written with the block idle: every expected
  // word has arrived and the drain time has passed, since a word that
  // causes no result may still be in flight.
  task automatic write_timeout(logic [15:0] ticks);
    s_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.timeout_ticks = ticks;
  endtask

  // Mostly well-formed polling: a tick while no reply is due, a reply while
  // one is. Around that come bursts of ticks that let a reply time out,
  // starts that overrun or restart the sweep, stray replies and ignored
  // words. The predicted state steers the choice, so sweeps run to the end.
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    logic [1:0]  op;
    sent = 0;
    while (sent < n_items) begin
      pick  = $urandom_range(0, 999);
      burst = 1;
      if (!sb.sweeping) begin
        if (pick < 850)      op = OP_START;
        else if (pick < 900) op = OP_TICK;
        else if (pick < 950) op = OP_REPLY;
        else                 op = OP_UNUSED;
      end else if (sb.reply_due) begin
        if (pick < 20) begin
          op = OP_START;
        end else if (pick < 100) begin
          op    = OP_TICK;
          burst = $urandom_range(1, 4);
        end else if (pick < 130) begin
          op = OP_UNUSED;
        end else begin
          op = OP_REPLY;
        end
      end else begin
        if (pick < 3)       op = OP_START;
        else if (pick < 60) op = OP_REPLY;
        else if (pick < 90) op = OP_UNUSED;
        else                op = OP_TICK;
      end
      repeat (burst) begin
        send_word(op, $urandom());
        if (op != OP_UNUSED) sent++;
      end
    end
  endtask

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (m_valid && m_ready) sb.check_output(m_user, m_data);
  end

  // Result side: random stalls, none while steady, and once a long hold-off
  // while the sender is offering words.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && s_valid && sb.results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_ready <= steady || ($urandom_range(0, 99) >= 8);
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  initial begin
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < StallLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("heating_channel_poll_sequencer regression: fail");
    $finish;
  end

  initial begin
    result_t left;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with a two-tick timeout so a lost reply comes quickly.
    write_timeout(16'd2);
    send_word(OP_TICK, $urandom());                         // idle tick: nothing
    send_word(OP_REPLY, 32'hFFFF_FFFF);                     // reply in the idle phase
    send_word(OP_UNUSED, 32'hFFFF_FFFF);                    // ignored selector
    send_word(OP_START, $urandom());
    send_word(OP_TICK, $urandom());                         // status request, channel 0
    send_word(OP_START, $urandom());                        // overrun while waiting
    send_word(OP_REPLY, reply_word(8'h12, 8'h00, 8'h40, 8'h00)); // unused channel
    send_word(OP_TICK, $urandom());                         // channel 1 status request
    send_word(OP_REPLY, reply_word(8'h12, 8'h00, 8'h3F, 8'h00)); // output on, sensor lost
    send_word(OP_TICK, $urandom());                         // element read is skipped
    send_word(OP_REPLY, reply_word(8'hFF, 8'hFF, 8'h00, 8'h00)); // largest target
    send_word(OP_TICK, $urandom());
    send_word(OP_REPLY, reply_word(8'hFF, 8'h00, 8'h00, 8'h00)); // mode 7
    send_word(OP_TICK, $urandom());                         // channel 2
    send_word(OP_REPLY, reply_word(8'h00, 8'h00, 8'hFF, 8'h00)); // element 63
    send_word(OP_TICK, $urandom());                         // element request
    send_word(OP_REPLY, reply_word(8'hFF, 8'hFF, 8'h00, 8'hFF)); // largest temp, battery
    send_word(OP_TICK, $urandom());                         // target request
    // No reply: the third tick finds the timeout reached and moves on to
    // channel 3 in the same step.
    repeat (3) send_word(OP_TICK, $urandom());
    send_word(OP_REPLY, reply_word(8'h00, 8'h00, 8'h01, 8'h00));
    send_word(OP_REPLY, reply_word(8'h10, 8'h00, 8'h05, 8'h00)); // second, unasked reply
    send_word(OP_START, $urandom());                        // restart with nothing due
    send_word(OP_TICK, $urandom());
    send_word(OP_REPLY, reply_word(8'h00, 8'h00, 8'h00, 8'h00));

    // Random part over several timeout settings, among them 1 and the largest.
    write_timeout(16'd1);
    run_random(215);
    steady = 1'b1;
    write_timeout(16'hFFFF);
    run_random(210);
    steady = 1'b0;
    write_timeout(16'($urandom_range(2, 8)));
    run_random(215);
    write_timeout(16'd3);
    run_random(210);

    s_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    while (sb.due_results.size() != 0) begin
      left = sb.due_results.pop_front();
      sb.report_mismatch($sformatf("expected result of kind %0d never arrived", left.kind));
    end
    if (sb.mismatches == 0) begin
      $display("heating_channel_poll_sequencer regression: pass");
    end else begin
      $display("heating_channel_poll_sequencer regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hcps_pkg.sv
design/hcps_core.sv
design/heating_channel_poll_sequencer.sv
tb/hcps_tb_pkg.sv
tb/heating_channel_poll_sequencer_test.sv
